// ----- rtl/sysex_seven_bit_packer_top_macros.svh -----
// Assertion macros for the seven-bit SysEx packer checker.
// Each macro expects signals named clk and arst_n in the scope of use.
`ifndef SYSEX_SEVEN_BIT_PACKER_TOP_MACROS_SVH
`define SYSEX_SEVEN_BIT_PACKER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SSPK_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define SSPK_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/sspk_pkg.sv -----
// ----------------------------------------------------------------------------
// sspk_pkg
// Shared types and constants for the seven-bit SysEx packer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sspk_pkg;

	localparam int unsigned GROUP_BYTES     = 7;
	localparam int unsigned OUT_SLOTS       = GROUP_BYTES + 1;
	localparam int unsigned CNT_W           = 3;
	localparam int unsigned REM_W           = 4;
	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	localparam logic [CNT_W-1:0] TOP_POS   = 3'd6;
	localparam logic [6:0]       LOW7_MASK = 7'h7f;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_word_t;

	typedef struct packed {
		logic [6:0] out_byte;
		logic       out_last;
	} out_word_t;

	// One finished group: header, bodies in arrival order, number of bodies.
	typedef struct packed {
		logic [6:0]                   header;
		logic [GROUP_BYTES-1:0][6:0]  bodies;
		logic [CNT_W-1:0]             count;
	} group_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// ----- rtl/sspk_front.sv -----
// ----------------------------------------------------------------------------
// sspk_front
// Accepts input words, gathers bodies and header bits, and pushes each
// finished group into the group queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sspk_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               flip,
	input  logic               in_valid,
	output logic               in_stall,
	input  sspk_pkg::in_word_t in_word,
	input  sspk_pkg::q_status_t q_status,
	output logic               push,
	output sspk_pkg::group_t   push_group
);
	import sspk_pkg::*;

	logic [6:0]       hdr_q;
	logic [CNT_W-1:0] cnt_q;
	logic [6:0]       body_q [GROUP_BYTES];

	logic             accept;
	logic             close;
	logic [CNT_W-1:0] pos;
	logic [6:0]       hdr_next;

	assign in_stall = q_status.full;
	assign accept   = in_valid && !in_stall;
	assign close    = (cnt_q == TOP_POS) || in_word.last_byte;
	assign push     = accept && close;

	assign pos      = flip ? cnt_q : (TOP_POS - cnt_q);
	assign hdr_next = (hdr_q | (7'(in_word.data_byte[7]) << pos)) & LOW7_MASK;

	always_comb begin
		push_group.header = hdr_next;
		push_group.count  = cnt_q + 3'd1;
		for (int i = 0; i < int'(GROUP_BYTES); i++) begin
			push_group.bodies[i] = (cnt_q == CNT_W'(i)) ? in_word.data_byte[6:0] : body_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			if (close) begin
				hdr_q <= '0;
				cnt_q <= '0;
			end else begin
				hdr_q <= hdr_next;
				cnt_q <= cnt_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			body_q[cnt_q] <= in_word.data_byte[6:0];
		end
	end

endmodule

// ----- rtl/sspk_queue.sv -----
// ----------------------------------------------------------------------------
// sspk_queue
// Short queue of finished groups between the front and the serialiser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sspk_queue #(
	parameter int unsigned DEPTH = sspk_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sspk_pkg::group_t    push_group,
	input  logic                pop,
	output sspk_pkg::group_t    head_group,
	output sspk_pkg::q_status_t q_status
);
	import sspk_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned FILL_W = $clog2(DEPTH + 1);

	group_t            entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;

	assign q_status.full  = (fill_q == FILL_W'(DEPTH));
	assign q_status.empty = (fill_q == '0);
	assign head_group     = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_group;
		end
	end

endmodule

// ----- rtl/sspk_back.sv -----
// ----------------------------------------------------------------------------
// sspk_back
// Serialiser: loads a group from the queue and sends the header and then the
// bodies, one word per unstalled cycle, through an output shift register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sspk_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sspk_pkg::group_t     head_group,
	input  sspk_pkg::q_status_t  q_status,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output sspk_pkg::out_word_t  out_word
);
	import sspk_pkg::*;

	logic [6:0]       sr_q [OUT_SLOTS];
	logic [REM_W-1:0] rem_q;
	logic             take;

	assign out_valid         = (rem_q != '0);
	assign out_word.out_byte = sr_q[0];
	assign out_word.out_last = (rem_q == 4'd1);
	assign take              = out_valid && !out_stall;

	// A new group may load as the last word of the previous one leaves.
	assign pop = !q_status.empty && (!out_valid || (take && out_word.out_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (pop) begin
			rem_q <= {1'b0, head_group.count} + 4'd1;
		end else if (take) begin
			rem_q <= rem_q - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			sr_q[0] <= head_group.header;
			for (int i = 0; i < int'(GROUP_BYTES); i++) begin
				sr_q[i+1] <= head_group.bodies[i];
			end
		end else if (take) begin
			for (int i = 0; i < int'(OUT_SLOTS) - 1; i++) begin
				sr_q[i] <= sr_q[i+1];
			end
		end
	end

endmodule

// ----- rtl/sysex_seven_bit_packer_top.sv -----
// Path: a word that closes a group is written into the group queue, then
// loaded into the serialiser when it is free; its header leads, bodies follow.
// Throughput: one input word per cycle while the group queue has room; the
// serialiser sends one output word per unstalled cycle; seven inputs give eight.
// Reset clears the header, counts, mode bit and queue; body stores are not
// cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// sysex_seven_bit_packer_top
// Packs 8-bit words into 7-bit SysEx groups of a header and up to seven bodies.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sysex_seven_bit_packer_top #(
	parameter int unsigned QUEUE_DEPTH = sspk_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic                cfg_wr_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  sspk_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_stall,
	output sspk_pkg::out_word_t out_word
);
	import sspk_pkg::*;

	logic      flip_header_bits_q;
	logic      push;
	logic      pop;
	group_t    push_group;
	group_t    head_group;
	q_status_t q_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flip_header_bits_q <= 1'b0;
		end else if (cfg_wr_en) begin
			flip_header_bits_q <= cfg_wr_data;
		end
	end

	sspk_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.flip       (flip_header_bits_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_word    (in_word),
		.q_status   (q_status),
		.push       (push),
		.push_group (push_group)
	);

	sspk_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_group (push_group),
		.pop        (pop),
		.head_group (head_group),
		.q_status   (q_status)
	);

	sspk_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_group (head_group),
		.q_status   (q_status),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_word   (out_word)
	);

endmodule

// ----- rtl/sspk_checker.sv -----
// ----------------------------------------------------------------------------
// sspk_checker
// Port-level checks for the packer: output handshake and group run length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "sysex_seven_bit_packer_top_macros.svh"

module sspk_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                out_valid,
	input  logic                out_stall,
	input  sspk_pkg::out_word_t out_word
);
	import sspk_pkg::*;

	// Number of words already sent in the current output run.
	logic [CNT_W-1:0] run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
		end else if (out_valid && !out_stall) begin
			run_q <= out_word.out_last ? '0 : run_q + 3'd1;
		end
	end

	`SSPK_ASSERT_NEXT(a_valid_holds, out_valid && out_stall, out_valid,
		"output valid dropped while stalled")
	`SSPK_ASSERT_NEXT(a_word_holds, out_valid && out_stall, $stable(out_word),
		"output word changed while stalled")
	`SSPK_ASSERT_NOW(a_header_not_last, out_valid && (run_q == '0), !out_word.out_last,
		"a header word was marked last")
	`SSPK_ASSERT_NOW(a_run_max, out_valid && (run_q == TOP_POS + 3'd1), out_word.out_last,
		"a run went past eight words")

endmodule

bind sysex_seven_bit_packer_top sspk_checker u_sspk_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_word  (out_word)
);
